[hw/rtl/assert_macros.svh]
// Assertion macros shared by the rectangle fill sequencer RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define LRFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next, outside reset
`define LRFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lrfs_pkg.sv]
// Package for the rectangle fill byte sequencer: codes, config and queue types.
// No dependencies; imported by the queue, front, back and top level modules.
package lrfs_pkg;

  // Input command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int SCREEN_W   = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_COLUMN_CMD    = 3'd2,
    CFG_ROW_CMD       = 3'd3,
    CFG_MEMWRITE_CMD  = 3'd4
  } cfg_idx_e_t;

  typedef struct packed {
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic [7:0]          column_cmd;
    logic [7:0]          row_cmd;
    logic [7:0]          memwrite_cmd;
  } cfg_t;

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd320;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd480;
  localparam logic [7:0]          COLUMN_CMD_RST    = 8'h2A;
  localparam logic [7:0]          ROW_CMD_RST       = 8'h2B;
  localparam logic [7:0]          MEMWRITE_CMD_RST  = 8'h2C;

  // Classified operation passed from front to back
  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_LOAD    = 2'd1,
    OP_DROP    = 2'd2
  } op_e_t;

  typedef struct packed {
    op_e_t       op;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] color;
  } q_entry_t;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Position in the panel stream: header bytes, then pixel phase
  typedef enum logic [3:0] {
    HDR_COL_CMD = 4'd0,
    HDR_X0_HI   = 4'd1,
    HDR_X0_LO   = 4'd2,
    HDR_X1_HI   = 4'd3,
    HDR_X1_LO   = 4'd4,
    HDR_ROW_CMD = 4'd5,
    HDR_Y0_HI   = 4'd6,
    HDR_Y0_LO   = 4'd7,
    HDR_Y1_HI   = 4'd8,
    HDR_Y1_LO   = 4'd9,
    HDR_MEMWR   = 4'd10,
    HDR_PIXEL   = 4'd11
  } hdr_e_t;

endpackage

[hw/rtl/lrfs_if.sv]
// Valid/ready channel interfaces for request input and byte output.
// Standalone; used by the front, back and top level modules.
interface lrfs_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] x_start;
  logic [15:0] y_start;
  logic [15:0] rect_width;
  logic [15:0] rect_height;
  logic [15:0] fill_color;

  modport source (output valid, cmd, x_start, y_start, rect_width, rect_height,
                  fill_color, input ready);
  modport sink   (input valid, cmd, x_start, y_start, rect_width, rect_height,
                  fill_color, output ready);
endinterface

interface lrfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last;

  modport source (output valid, out_byte, is_data, last, input ready);
  modport sink   (input valid, out_byte, is_data, last, output ready);
endinterface

[hw/rtl/lrfs_queue.sv]
// Short register queue carrying classified operations from front to back.
// Depends on lrfs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lrfs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lrfs_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output lrfs_pkg::q_entry_t  pop_entry,
  output logic                full,
  output logic                empty
);
  import lrfs_pkg::*;

  q_entry_t          q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign empty     = (count_r == '0);
  assign pop_entry = q_mem_r[rd_ptr_r];

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed entries; payload needs no reset
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_entry;
    end
  end

  `LRFS_ASSERT(a_no_overflow, !(push && full), "push into full queue")
  `LRFS_ASSERT(a_no_underflow, !(pop && empty), "pop from empty queue")
  `LRFS_ASSERT_NEXT(a_count_bound, 1'b1, count_r <= QCNT_W'(QDEPTH), "queue count out of range")

endmodule

[hw/rtl/lrfs_front.sv]
// Front end: accepts requests, classifies them and clips loads to the screen.
// Depends on lrfs_pkg and lrfs_if.
module lrfs_front (
  lrfs_in_if.sink             in_ch,
  input  lrfs_pkg::cfg_t      cfg,
  input  logic                q_full,
  output logic                push,
  output lrfs_pkg::q_entry_t  push_entry
);
  import lrfs_pkg::*;

  logic [15:0] sw16, sh16;
  logic [16:0] x_end, y_end;
  logic        off_screen, x_clip, y_clip;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign sw16 = {3'b000, cfg.screen_width};
  assign sh16 = {3'b000, cfg.screen_height};

  // Compare start and inclusive end against the screen limits
  assign off_screen = (in_ch.x_start >= sw16) || (in_ch.y_start >= sh16);
  assign x_end  = {1'b0, in_ch.x_start} + {1'b0, in_ch.rect_width} - 17'd1;
  assign y_end  = {1'b0, in_ch.y_start} + {1'b0, in_ch.rect_height} - 17'd1;
  assign x_clip = (in_ch.rect_width != '0) && (x_end >= {1'b0, sw16});
  assign y_clip = (in_ch.rect_height != '0) && (y_end >= {1'b0, sh16});

  // Build the queue entry; a clipped end is the last column or row
  always_comb begin
    push_entry.op = OP_LOAD;
    if (in_ch.cmd == CMD_ADVANCE) begin
      push_entry.op = OP_ADVANCE;
    end else if (off_screen) begin
      push_entry.op = OP_DROP;
    end
    push_entry.x0     = in_ch.x_start;
    push_entry.y0     = in_ch.y_start;
    push_entry.width  = x_clip ? sw16 - in_ch.x_start : in_ch.rect_width;
    push_entry.height = y_clip ? sh16 - in_ch.y_start : in_ch.rect_height;
    push_entry.x1     = x_clip ? sw16 - 16'd1 : in_ch.x_start + in_ch.rect_width - 16'd1;
    push_entry.y1     = y_clip ? sh16 - 16'd1 : in_ch.y_start + in_ch.rect_height - 16'd1;
    push_entry.color  = in_ch.fill_color;
  end

endmodule

[hw/rtl/lrfs_back.sv]
// Back end: holds the run state and produces one stream byte per advance while a run is armed.
// Depends on lrfs_pkg, lrfs_if and assert_macros.svh.
`include "assert_macros.svh"

module lrfs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lrfs_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  lrfs_pkg::q_entry_t  q_entry,
  output logic                pop,
  lrfs_out_if.source          out_ch
);
  import lrfs_pkg::*;

  logic        busy_r, busy_nxt;
  hdr_e_t      hdr_r, hdr_nxt;
  logic [15:0] x0_r, x0_nxt, y0_r, y0_nxt, x1_r, x1_nxt, y1_r, y1_nxt;
  logic [15:0] cols_r, cols_nxt, rows_r, rows_nxt, row_len_r, row_len_nxt;
  logic [15:0] color_r, color_nxt;
  logic        low_r, low_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        is_data_r, is_data_nxt;
  logic        last_r, last_nxt;
  logic        emit, emit_last;
  logic [15:0] cols_dec;
  logic        pix_run, counts_live, emit_fin;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.is_data  = is_data_r;
  assign out_ch.last     = last_r;

  // Take the next operation whenever the output register can be refilled
  assign pop      = !q_empty && (!out_valid_r || out_ch.ready);
  assign emit     = pop && (q_entry.op == OP_ADVANCE) && busy_r;
  assign cols_dec = cols_r - 16'd1;

  // Sequencer step and output byte selection
  always_comb begin
    busy_nxt      = busy_r;
    hdr_nxt       = hdr_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    row_len_nxt   = row_len_r;
    color_nxt     = color_r;
    low_nxt       = low_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    is_data_nxt   = is_data_r;
    last_nxt      = last_r;
    emit_last     = 1'b0;

    if (pop && q_entry.op == OP_LOAD) begin
      // Arm a new run from the clipped window
      busy_nxt    = 1'b1;
      hdr_nxt     = HDR_COL_CMD;
      x0_nxt      = q_entry.x0;
      y0_nxt      = q_entry.y0;
      x1_nxt      = q_entry.x1;
      y1_nxt      = q_entry.y1;
      cols_nxt    = q_entry.width;
      row_len_nxt = q_entry.width;
      rows_nxt    = q_entry.height;
      color_nxt   = q_entry.color;
      low_nxt     = 1'b0;
    end else if (pop && q_entry.op == OP_DROP) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      out_valid_nxt = 1'b1;
      is_data_nxt   = 1'b1;
      if (hdr_r != HDR_PIXEL) begin
        hdr_nxt = hdr_e_t'(hdr_r + 4'd1);
        case (hdr_r)
          HDR_COL_CMD: begin
            out_byte_nxt = cfg.column_cmd;
            is_data_nxt  = 1'b0;
          end
          HDR_X0_HI: out_byte_nxt = x0_r[15:8];
          HDR_X0_LO: out_byte_nxt = x0_r[7:0];
          HDR_X1_HI: out_byte_nxt = x1_r[15:8];
          HDR_X1_LO: out_byte_nxt = x1_r[7:0];
          HDR_ROW_CMD: begin
            out_byte_nxt = cfg.row_cmd;
            is_data_nxt  = 1'b0;
          end
          HDR_Y0_HI: out_byte_nxt = y0_r[15:8];
          HDR_Y0_LO: out_byte_nxt = y0_r[7:0];
          HDR_Y1_HI: out_byte_nxt = y1_r[15:8];
          HDR_Y1_LO: out_byte_nxt = y1_r[7:0];
          HDR_MEMWR: begin
            out_byte_nxt = cfg.memwrite_cmd;
            is_data_nxt  = 1'b0;
            emit_last    = (cols_r == '0) || (rows_r == '0);
            if (emit_last) begin
              busy_nxt = 1'b0;
            end
          end
          default: out_byte_nxt = '0;
        endcase
      end else if (!low_r) begin
        // High byte of the pixel
        out_byte_nxt = color_r[15:8];
        low_nxt      = 1'b1;
      end else begin
        // Low byte of the pixel; step the column and row counts
        out_byte_nxt = color_r[7:0];
        low_nxt      = 1'b0;
        emit_last    = (cols_r == 16'd1) && (rows_r == 16'd1);
        if (emit_last) begin
          busy_nxt = 1'b0;
          cols_nxt = '0;
          rows_nxt = '0;
        end else if (cols_dec == '0) begin
          cols_nxt = row_len_r;
          rows_nxt = rows_r - 16'd1;
        end else begin
          cols_nxt = cols_dec;
        end
      end
      last_nxt = emit_last;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      hdr_r       <= HDR_COL_CMD;
      low_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      hdr_r       <= hdr_nxt;
      low_r       <= low_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Window, counters and output payload
  always_ff @(posedge clk) begin
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    cols_r     <= cols_nxt;
    rows_r     <= rows_nxt;
    row_len_r  <= row_len_nxt;
    color_r    <= color_nxt;
    out_byte_r <= out_byte_nxt;
    is_data_r  <= is_data_nxt;
    last_r     <= last_nxt;
  end

  // Terms for the checks below
  assign pix_run     = busy_r && (hdr_r == HDR_PIXEL);
  assign counts_live = (cols_r != '0) && (rows_r != '0);
  assign emit_fin    = emit && emit_last;

  `LRFS_ASSERT(a_pixel_counts_live, !pix_run || counts_live, "pixel phase with empty count")
  `LRFS_ASSERT_NEXT(a_last_ends_run, emit_fin, !busy_r && out_valid_r && last_r, "run not ended")
  `LRFS_ASSERT_NEXT(a_emit_fills_out, emit, out_valid_r, "emitted byte not presented")

endmodule

[hw/rtl/lcd_rect_fill_byte_sequencer.sv]
// Rectangle fill byte sequencer for a serial LCD panel.
// Input channel in_ch carries transactions: cmd 0 loads a rectangle request
// (x_start, y_start, rect_width, rect_height, fill_color), cmd 1 advances the
// stream by one byte. Each advance while a run is armed yields one transaction
// on out_ch: out_byte, is_data (0 command, 1 data) and last on the final byte.
// Loads and advances while idle yield nothing; a load aborts any run in progress.
// Path: the byte of an advance passes through the front-to-back queue and then
// the output register before it appears on out_ch.
// Throughput: one transaction per clock while the receiver does not stall; the
// front-to-back queue lets a new transaction be accepted while the previous
// byte still waits. When the receiver stalls, the output holds, the two-entry
// queue fills and in_ch.ready drops.
// Reset (rst_n low, synchronous): no run armed, queue and output empty, config
// registers back to 320 x 480 and command bytes 0x2A, 0x2B, 0x2C.
// Configuration: cfg_we writes cfg_wdata into register cfg_idx; write only
// while the block is idle.
// Depends on lrfs_pkg, lrfs_if, lrfs_queue, lrfs_front and lrfs_back.
module lcd_rect_fill_byte_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lrfs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [lrfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  lrfs_in_if.sink                           in_ch,
  lrfs_out_if.source                        out_ch
);
  import lrfs_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     q_push, q_pop, q_full, q_empty;
  q_entry_t q_push_entry, q_pop_entry;

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_wdata[SCREEN_W-1:0];
        CFG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_wdata[SCREEN_W-1:0];
        CFG_COLUMN_CMD:    cfg_nxt.column_cmd    = cfg_wdata[7:0];
        CFG_ROW_CMD:       cfg_nxt.row_cmd       = cfg_wdata[7:0];
        CFG_MEMWRITE_CMD:  cfg_nxt.memwrite_cmd  = cfg_wdata[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= SCREEN_WIDTH_RST;
      cfg_r.screen_height <= SCREEN_HEIGHT_RST;
      cfg_r.column_cmd    <= COLUMN_CMD_RST;
      cfg_r.row_cmd       <= ROW_CMD_RST;
      cfg_r.memwrite_cmd  <= MEMWRITE_CMD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lrfs_front u_front (
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  lrfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .pop_entry  (q_pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  lrfs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_entry (q_pop_entry),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

endmodule
